### rtl/crc8fr_pkg.sv
// Shared types, constants and the CRC-8 byte update for the CRC-8 frame receiver.
`default_nettype none

package crc8fr_pkg;

  // Frame format constants.
  localparam logic [7:0]  HdrFirst       = 8'hFE;
  localparam logic [7:0]  HdrSecond      = 8'hFF;
  localparam logic [7:0]  CrcPoly        = 8'h07;
  localparam logic [7:0]  CrcInit        = 8'h00;
  localparam logic [23:0] LenSat         = 24'hFF_FFFF;
  localparam logic [23:0] MaxLenReset    = 24'd4096;
  localparam int          LenFieldBytesDef = 4;
  localparam int          LenAccumW      = 32;
  localparam int          LenIdxW        = 2;

  // Status codes carried on end-of-frame items.
  localparam logic [1:0]  StOk     = 2'd0;
  localparam logic [1:0]  StBadCrc = 2'd1;
  localparam logic [1:0]  StBadLen = 2'd2;

  // Packed widths of the output item.
  localparam int OutDataW = 40;

  // One result from the parser toward the output register.
  typedef struct packed {
    logic        valid;
    logic        is_status;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [23:0] frame_length;
  } crc8fr_res_t;

  // CRC-8 over one byte, MSB first, no reflection, no final XOR.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/crc8fr_parser.sv
// Frame parser: header hunt, length collection, CRC tracking and result formation.
`default_nettype none

module crc8fr_parser #(
  parameter int LenFieldBytes = crc8fr_pkg::LenFieldBytesDef
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       accept_i,
  input  wire  [7:0]                in_byte_i,
  input  wire  [23:0]               max_len_i,
  output crc8fr_pkg::crc8fr_res_t   res_o
);
  import crc8fr_pkg::*;

  // Parser phases.
  localparam logic [2:0] PhHunt1   = 3'd0;
  localparam logic [2:0] PhHunt2   = 3'd1;
  localparam logic [2:0] PhLen     = 3'd2;
  localparam logic [2:0] PhPayload = 3'd3;
  localparam logic [2:0] PhCheck   = 3'd4;

  localparam logic [2:0] LenBytes = 3'(LenFieldBytes);

  logic [2:0]           phase_q, phase_d;
  logic [LenAccumW-1:0] accum_q, accum_d;
  logic [LenIdxW-1:0]   idx_q, idx_d;
  logic [23:0]          remain_q, remain_d;
  logic [7:0]           crc_q, crc_d;

  logic [LenAccumW-1:0] accum_new;
  logic [23:0]          len_sat;
  logic [23:0]          remain_dec;
  logic [7:0]           crc_next;
  crc8fr_res_t          res;

  // Length field with the current byte merged in.
  always_comb begin
    accum_new = accum_q;
    accum_new[{idx_q, 3'b000} +: 8] = accum_q[{idx_q, 3'b000} +: 8] | in_byte_i;
  end

  assign remain_dec = remain_q - 24'd1;
  assign crc_next   = crc8_update(crc_q, in_byte_i);

  // Next state and result for the byte on the input.
  always_comb begin
    phase_d  = phase_q;
    accum_d  = accum_q;
    idx_d    = idx_q;
    remain_d = remain_q;
    crc_d    = crc_q;
    res      = '0;
    len_sat  = (accum_q > LenAccumW'(LenSat)) ? LenSat : accum_q[23:0];
    unique case (phase_q)
      PhHunt1: begin
        if (in_byte_i == HdrFirst) begin
          phase_d = PhHunt2;
        end
      end
      PhHunt2: begin
        if (in_byte_i == HdrSecond) begin
          phase_d = PhLen;
          accum_d = '0;
          idx_d   = '0;
        end else if (in_byte_i != HdrFirst) begin
          phase_d = PhHunt1;
        end
      end
      PhLen: begin
        accum_d = accum_new;
        len_sat = (accum_new > LenAccumW'(LenSat)) ? LenSat : accum_new[23:0];
        if (({1'b0, idx_q} + 3'd1) < LenBytes) begin
          idx_d = idx_q + LenIdxW'(1);
        end else begin
          idx_d = '0;
          if ((accum_new == '0) || (accum_new > LenAccumW'(max_len_i))) begin
            phase_d          = PhHunt1;
            res.valid        = 1'b1;
            res.is_status    = 1'b1;
            res.status       = StBadLen;
            res.frame_length = len_sat;
          end else begin
            crc_d    = CrcInit;
            remain_d = accum_new[23:0] - 24'd1;
            phase_d  = (accum_new[23:0] == 24'd1) ? PhCheck : PhPayload;
          end
        end
      end
      PhPayload: begin
        crc_d            = crc_next;
        remain_d         = remain_dec;
        res.valid        = 1'b1;
        res.payload_byte = in_byte_i;
        if (remain_dec == 24'd0) begin
          phase_d = PhCheck;
        end
      end
      PhCheck: begin
        phase_d          = PhHunt1;
        res.valid        = 1'b1;
        res.is_status    = 1'b1;
        res.status       = (in_byte_i == crc_q) ? StOk : StBadCrc;
        res.frame_length = len_sat;
      end
      default: begin
        phase_d = PhHunt1;
      end
    endcase
  end

  // State registers advance only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt1;
      accum_q  <= '0;
      idx_q    <= '0;
      remain_q <= '0;
      crc_q    <= CrcInit;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      accum_q  <= accum_d;
      idx_q    <= idx_d;
      remain_q <= remain_d;
      crc_q    <= crc_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

### rtl/crc8_frame_receiver_top.sv
// Top level of the CRC-8 frame receiver: stream ports, configuration and output register.
//
// Usage: received bytes enter on the s_axis channel, one byte per item in
// s_axis_tdata[7:0]. The receiver hunts the header 0xFE 0xFF, gathers a
// little-endian length (payload plus check byte), forwards each payload byte
// and finally reports a status. Results leave on the m_axis channel; tuser
// marks a status item, tdata carries payload byte, status and frame length.
// The cfg channel writes the maximum accepted length (reset 4096); write it
// only while no frame is in flight.
// Output: a result is registered and appears on m_axis in the cycle after its input byte is taken.
// Throughput: one byte per cycle while m_axis is not stalled; the parser state updates in one pass of
// logic, with the CRC-8 byte update as an unrolled XOR network.
// Stall: s_axis_tready is high whenever the output register is empty or being
// drained in the same cycle, so a stalled m_axis holds one result and stops
// input until it is taken.
// Reset: the parser returns to header hunting, the output register empties
// and the maximum length returns to 4096.
`default_nettype none

module crc8_frame_receiver_top #(
  parameter int LenFieldBytes = crc8fr_pkg::LenFieldBytesDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Input stream
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [7:0]                   s_axis_tdata,   // [7:0] in_byte
  // Output stream
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [crc8fr_pkg::OutDataW-1:0] m_axis_tdata, // [7:0] payload_byte, [9:8] status,
                                                        // [33:10] frame_length, rest zero
  output logic                         m_axis_tuser,   // [0] is_status
  // Configuration write
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [23:0]                  cfg_data_i      // max_frame_length
);
  import crc8fr_pkg::*;

  logic [23:0]          max_len_q;
  logic                 accept;
  crc8fr_res_t          res;
  logic                 out_valid_q;
  logic                 out_user_q;
  logic [OutDataW-1:0]  out_data_q;

  // Configuration register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Input is taken when the output register is free or draining.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  crc8fr_parser #(
    .LenFieldBytes(LenFieldBytes)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (s_axis_tdata),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= accept && res.valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (accept && res.valid) begin
      out_user_q <= res.is_status;
      out_data_q <= {(OutDataW - 34)'(0), res.frame_length, res.status, res.payload_byte};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

  // A full, stalled output register must block the input side.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output register is stalled");

  // Payload items carry no status or length.
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[33:8] == 26'd0))
    else $error("payload item with nonzero status or length");

  // Status code stays within the defined codes.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[9:8] == StOk || m_axis_tdata[9:8] == StBadCrc ||
                       m_axis_tdata[9:8] == StBadLen))
    else $error("undefined status code on output");

endmodule

`default_nettype wire
